### hdl/rldm_pkg.sv
// ----------------------------------------------------------------------------
// rldm_pkg: shared definitions for the radial light dither mask.
// Register map, reset values, the Bayer order and the falloff factor tables.
// ----------------------------------------------------------------------------
package rldm_pkg;

    localparam int RADIUS_W   = 6;
    localparam int STRENGTH_W = 3;
    localparam int PIX_W      = 7;
    localparam int ALPHA_W    = 8;
    localparam int KFACT_W    = 17;
    localparam int R2_W       = 2 * RADIUS_W;
    localparam int SQ_W       = 2 * PIX_W;
    localparam int D2_W       = SQ_W + 1;
    localparam int R2K_W      = R2_W + KFACT_W;
    localparam int KFRAC_W    = 16;

    localparam logic [RADIUS_W-1:0]   MAX_RADIUS     = 6'd63;
    localparam logic [RADIUS_W-1:0]   RADIUS_RESET   = 6'd8;
    localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 3'd5;
    localparam logic [STRENGTH_W-1:0] STRENGTH_MAX   = 3'd5;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_RADIUS   = 1'b0;
    localparam logic REG_STRENGTH = 1'b1;

    // 4x4 Bayer order entry for row y%4, column x%4.
    function automatic logic [3:0] bayer_entry(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] idx;
        logic [3:0] val;
        idx = {row, col};
        unique case (idx)
            4'd0:  val = 4'd0;
            4'd1:  val = 4'd8;
            4'd2:  val = 4'd2;
            4'd3:  val = 4'd10;
            4'd4:  val = 4'd12;
            4'd5:  val = 4'd4;
            4'd6:  val = 4'd14;
            4'd7:  val = 4'd6;
            4'd8:  val = 4'd3;
            4'd9:  val = 4'd11;
            4'd10: val = 4'd1;
            4'd11: val = 4'd9;
            4'd12: val = 4'd15;
            4'd13: val = 4'd7;
            4'd14: val = 4'd13;
            default: val = 4'd5;
        endcase
        return val;
    endfunction

    // Falloff factor (1 - sqrt(b)/8)^2 in Q1.16, rounded to nearest.
    function automatic logic [KFACT_W-1:0] falloff_k(input logic [3:0] b);
        logic [KFACT_W-1:0] k;
        unique case (b)
            4'd0:  k = 17'd65536;
            4'd1:  k = 17'd50176;
            4'd2:  k = 17'd44414;
            4'd3:  k = 17'd40230;
            4'd4:  k = 17'd36864;
            4'd5:  k = 17'd34020;
            4'd6:  k = 17'd31548;
            4'd7:  k = 17'd29356;
            4'd8:  k = 17'd27387;
            4'd9:  k = 17'd25600;
            4'd10: k = 17'd23965;
            4'd11: k = 17'd22460;
            4'd12: k = 17'd21068;
            4'd13: k = 17'd19775;
            4'd14: k = 17'd18569;
            default: k = 17'd17441;
        endcase
        return k;
    endfunction

    // Alpha of a lit pixel: strength*255/5, with strength saturated at five.
    function automatic logic [ALPHA_W-1:0] lit_alpha(input logic [STRENGTH_W-1:0] s);
        logic [ALPHA_W-1:0] a;
        unique case (s)
            3'd0: a = 8'd0;
            3'd1: a = 8'd51;
            3'd2: a = 8'd102;
            3'd3: a = 8'd153;
            3'd4: a = 8'd204;
            default: a = 8'd255;
        endcase
        return a;
    endfunction

endpackage

### hdl/radial_light_dither_mask_core.sv
// ----------------------------------------------------------------------------
// radial_light_dither_mask_core: Bayer-dithered radial falloff light mask.
// Path: an accepted input is registered in stage 1, stage 2 and stage 3; stage 3 drives m_tvalid.
// Throughput: one pixel per cycle while the output is not stalled; the three-stage pipeline with the two
// squarers and the radius-times-factor multiplier sets that figure.
// Reset: pipeline valids clear, radius returns to 8 and strength to 5.
// ----------------------------------------------------------------------------
module radial_light_dither_mask_core
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Pixel input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [6:0] pix_x, [13:7] pix_y, [15:14] zero
    // Mask output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] lit, [8:1] alpha, [15:9] zero
);

    // ------------------------------------------------------------------------
    // Configuration registers. Writes are to be issued only while the block is
    // idle; the block does not enforce it. The pipeline stages read them directly.
    // ------------------------------------------------------------------------
    logic [rldm_pkg::RADIUS_W-1:0]   radius_reg;
    logic [rldm_pkg::STRENGTH_W-1:0] strength_reg;
    logic                            cfg_wr;
    logic                            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= rldm_pkg::RADIUS_RESET;
            strength_reg <= rldm_pkg::STRENGTH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                rldm_pkg::REG_RADIUS:   radius_reg   <= pwdata[rldm_pkg::RADIUS_W-1:0];
                rldm_pkg::REG_STRENGTH: strength_reg <= pwdata[rldm_pkg::STRENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            rldm_pkg::REG_RADIUS:
                prdata = {{(32-rldm_pkg::RADIUS_W){1'b0}}, radius_reg};
            default:
                prdata = {{(32-rldm_pkg::STRENGTH_W){1'b0}}, strength_reg};
        endcase
    end

    // Effective radius and strength after saturation.
    logic [rldm_pkg::RADIUS_W-1:0]   r_eff;
    logic [rldm_pkg::STRENGTH_W-1:0] s_eff;

    assign r_eff = (radius_reg > rldm_pkg::MAX_RADIUS) ? rldm_pkg::MAX_RADIUS : radius_reg;
    assign s_eff = (strength_reg > rldm_pkg::STRENGTH_MAX) ? rldm_pkg::STRENGTH_MAX
                                                           : strength_reg;

    // ------------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when the
    // stage after it is moving, so bubbles collapse and a stall holds in place
    // each occupied stage that has no empty stage after it.
    // ------------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= s_tvalid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: distances to the centre, mask bounds, Bayer entry, radius^2.
    // ------------------------------------------------------------------------
    logic [rldm_pkg::PIX_W-1:0] pix_x, pix_y, r_ext, r_twice;
    logic [rldm_pkg::PIX_W-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic                       in1_next, in1_reg;
    logic [3:0]                 b_next, b_reg;
    logic [rldm_pkg::R2_W-1:0]  r2a_next, r2a_reg;

    assign pix_x   = s_tdata[rldm_pkg::PIX_W-1:0];
    assign pix_y   = s_tdata[2*rldm_pkg::PIX_W-1:rldm_pkg::PIX_W];
    assign r_ext   = {1'b0, r_eff};
    assign r_twice = {r_eff, 1'b0};

    always_comb
    begin
        dx_next  = (pix_x >= r_ext) ? (pix_x - r_ext) : (r_ext - pix_x);
        dy_next  = (pix_y >= r_ext) ? (pix_y - r_ext) : (r_ext - pix_y);
        in1_next = (pix_x <= r_twice) && (pix_y <= r_twice);
        b_next   = rldm_pkg::bayer_entry(pix_y[1:0], pix_x[1:0]);
        r2a_next = r_eff * r_eff;
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            in1_reg <= in1_next;
            b_reg   <= b_next;
            r2a_reg <= r2a_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: squares of the offsets and the dither threshold radius^2*K[b].
    // ------------------------------------------------------------------------
    logic [rldm_pkg::SQ_W-1:0]  sqx_next, sqy_next, sqx_reg, sqy_reg;
    logic [rldm_pkg::R2K_W-1:0] r2k_next, r2k_reg;
    logic [rldm_pkg::R2_W-1:0]  r2b_reg;
    logic                       in2_reg;

    always_comb
    begin
        sqx_next = dx_reg * dx_reg;
        sqy_next = dy_reg * dy_reg;
        r2k_next = {{rldm_pkg::KFACT_W{1'b0}}, r2a_reg} * rldm_pkg::falloff_k(b_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            r2k_reg <= r2k_next;
            r2b_reg <= r2a_reg;
            in2_reg <= in1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: squared distance, the inner-disc and dither compares, alpha.
    // ------------------------------------------------------------------------
    logic [rldm_pkg::D2_W-1:0]            d2;
    logic [rldm_pkg::D2_W+1:0]            d2x4;
    logic [rldm_pkg::D2_W+rldm_pkg::KFRAC_W-1:0] d2s;
    logic                                 inner, dith;
    logic                                 lit_next, lit_reg;
    logic [rldm_pkg::ALPHA_W-1:0]         alpha_next, alpha_reg;

    always_comb
    begin
        d2         = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        d2x4       = {d2, 2'b00};
        d2s        = {d2, {rldm_pkg::KFRAC_W{1'b0}}};
        inner      = d2x4 <= {{(rldm_pkg::D2_W+2-rldm_pkg::R2_W){1'b0}}, r2b_reg};
        dith       = d2s < {{(rldm_pkg::D2_W+rldm_pkg::KFRAC_W-rldm_pkg::R2K_W){1'b0}},
                            r2k_reg};
        lit_next   = in2_reg && (inner || dith);
        alpha_next = lit_next ? rldm_pkg::lit_alpha(s_eff) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            lit_reg   <= lit_next;
            alpha_reg <= alpha_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(16-1-rldm_pkg::ALPHA_W){1'b0}}, alpha_reg, lit_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_unlit_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !lit_reg) |-> (alpha_reg == '0))
        else $error("unlit pixel carries nonzero alpha");

    a_lit_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && lit_reg) |-> (alpha_reg == rldm_pkg::lit_alpha(s_eff)))
        else $error("lit pixel alpha does not match strength");

    a_outside_unlit: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && adv3 && !in2_reg) |=> !lit_reg)
        else $error("pixel outside the mask came out lit");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !adv3) |=> (v2_reg && $stable(r2k_reg) && $stable(sqx_reg)))
        else $error("stage two changed while stalled");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> s_tready)
        else $error("empty pipeline refused input");

endmodule
